// ===== rtl/core/pctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, codes and default sizes of the prefix code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam int DEF_TABLE_DEPTH     = 256;
	localparam int DEF_MAX_CODE_LEN    = 16;
	localparam int DEF_MAX_SYMBOL_BITS = 8;

	// Request and result field widths.
	localparam int INDEX_W  = 8;
	localparam int CODE_W   = 16;
	localparam int LEN_W    = 5;
	localparam int SYMBOL_W = 8;

	// Configuration port.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int COUNT_W     = 9;
	localparam int SYMBITS_W   = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_BITS = CFG_INDEX_W'(1);

	localparam logic [SYMBITS_W-1:0] SYMBOL_BITS_RESET = SYMBITS_W'(2);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BIT  = 1'b1;

	localparam logic ST_SYMBOL   = 1'b0;
	localparam logic ST_OVERFLOW = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
		logic [SYMBOL_W-1:0] sym;
	} entry_t;

	typedef struct packed {
		logic                valid;
		logic [SYMBOL_W-1:0] symbol;
		logic                status;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PUSH
	} scan_state_t;

endpackage

// ===== rtl/core/pctd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pctd_req_if
	import pctd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                op;
	logic                code_bit;
	logic [INDEX_W-1:0]  entry_index;
	logic [CODE_W-1:0]   entry_code;
	logic [LEN_W-1:0]    entry_code_len;
	logic [SYMBOL_W-1:0] entry_symbol;

	modport source (output valid, op, code_bit, entry_index, entry_code, entry_code_len,
		entry_symbol, input ready);
	modport sink (input valid, op, code_bit, entry_index, entry_code, entry_code_len,
		entry_symbol, output ready);
endinterface

interface pctd_rsp_if
	import pctd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] symbol;
	logic                status;

	modport source (output valid, symbol, status, input ready);
	modport sink (input valid, symbol, status, output ready);
endinterface

interface pctd_cfg_if
	import pctd_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pctd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pctd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/pctd_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_scan
// Request handling, pending code register and the table search sequencer.
// ----------------------------------------------------------------------------
module pctd_scan
	import pctd_pkg::*;
#(
	parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
	parameter int MAX_CODE_LEN    = DEF_MAX_CODE_LEN,
	parameter int MAX_SYMBOL_BITS = DEF_MAX_SYMBOL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pctd_req_if.sink                       req,
	input  logic [COUNT_W-1:0]             entry_count,
	input  logic [SYMBITS_W-1:0]           symbol_bits,
	output logic                           mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
	output entry_t                         mem_wdata,
	output logic                           mem_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
	input  entry_t                         mem_rdata,
	output res_t                           res,
	input  logic                           res_take
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int LW   = $clog2(MAX_CODE_LEN + 1);
	localparam int CW   = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

	scan_state_t state_q, state_d;

	logic [MAX_CODE_LEN-1:0] pend_code_q;
	logic [LW-1:0]           pend_len_q;
	logic [CNTW-1:0]         idx_q;
	logic                    rd_vld_s1;
	logic [SYMBOL_W-1:0]     res_sym_q;
	logic                    res_status_q;

	logic            accept, load_req, bit_req;
	logic [CNTW-1:0] count_eff;
	logic            issue, hit, exhausted, overflow_end;
	logic [CW-1:0]   code_mask;
	logic [4:0]      sym_width;
	logic [31:0]     sym_masked;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load_req  = accept && (req.op == OP_LOAD);
	assign bit_req   = accept && (req.op == OP_BIT);

	// Loads aimed past the end of the table are dropped.
	assign mem_we    = load_req && (32'(req.entry_index) < TABLE_DEPTH);
	assign mem_waddr = AW'(req.entry_index);
	assign mem_wdata = '{code: req.entry_code, len: req.entry_code_len,
		sym: req.entry_symbol};

	assign count_eff = (32'(entry_count) > TABLE_DEPTH) ? CNTW'(TABLE_DEPTH)
		: CNTW'(entry_count);

	// Compare stage: the entry read last cycle against the pending code.
	assign code_mask = (CW'(1) << mem_rdata.len) - CW'(1);
	assign hit = rd_vld_s1 && (mem_rdata.len != '0)
		&& (32'(mem_rdata.len) == 32'(pend_len_q))
		&& ((CW'(mem_rdata.code) & code_mask) == CW'(pend_code_q));

	assign issue     = (state_q == S_SCAN) && (idx_q < count_eff) && !hit;
	assign mem_re    = issue;
	assign mem_raddr = idx_q[AW-1:0];

	assign exhausted    = (state_q == S_SCAN) && !rd_vld_s1 && (idx_q >= count_eff);
	assign overflow_end = exhausted && (32'(pend_len_q) >= MAX_CODE_LEN);

	assign sym_width = (5'(symbol_bits) > 5'(MAX_SYMBOL_BITS)) ? 5'(MAX_SYMBOL_BITS)
		: 5'(symbol_bits);
	assign sym_masked = 32'(mem_rdata.sym) & ((32'd1 << sym_width) - 32'd1);

	assign res = '{valid: (state_q == S_PUSH), symbol: res_sym_q, status: res_status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (bit_req) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || overflow_end) begin
					state_d = S_PUSH;
				end else if (exhausted) begin
					state_d = S_IDLE;
				end
			end
			S_PUSH: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_code_q <= '0;
			pend_len_q  <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (bit_req) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNTW'(1);
			end
			if (hit || overflow_end) begin
				pend_code_q <= '0;
				pend_len_q  <= '0;
			end else if (bit_req && (32'(pend_len_q) < MAX_CODE_LEN)) begin
				pend_code_q <= {pend_code_q[MAX_CODE_LEN-2:0], req.code_bit};
				pend_len_q  <= pend_len_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			res_sym_q    <= sym_masked[SYMBOL_W-1:0];
			res_status_q <= ST_SYMBOL;
		end else if (overflow_end) begin
			res_sym_q    <= '0;
			res_status_q <= ST_OVERFLOW;
		end
	end

endmodule

// ===== rtl/core/prefix_code_table_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_table_decoder
// Prefix code decoder with a loadable codeword table held in RAM.
// ----------------------------------------------------------------------------
// Requests on req either load one table slot (op = load) or push one code
// bit (op = bit). A load writes its slot and gives no result. A bit request
// extends the pending code and then walks the table from slot zero, one RAM
// read per cycle, until the first slot whose length and bits match or the
// entry_count slots (capped at TABLE_DEPTH) run out. A match gives a result
// with the symbol masked to symbol_bits; a miss gives no result, but at the
// maximum code length it gives an overflow result with symbol zero. A bit
// request holds off req until its search ends and any result is taken by the
// output register; the table has a single RAM read port.
// Results leave through an output register on rsp, so a stalled receiver
// holds at most one finished result there while the next search runs; a
// second result waits in the search unit until the register frees.
// cfg writes entry_count (index 0) and symbol_bits (index 1)
// and should only be used while the block is idle.
// Reset clears the pending code, entry_count and the channels and sets symbol_bits to 2;
// the table RAM is not cleared and must be loaded before it is searched.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder
	import pctd_pkg::*;
#(
	parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
	parameter int MAX_CODE_LEN    = DEF_MAX_CODE_LEN,
	parameter int MAX_SYMBOL_BITS = DEF_MAX_SYMBOL_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	pctd_req_if.sink   req,
	pctd_rsp_if.source rsp,
	pctd_cfg_if.sink   cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [COUNT_W-1:0]   entry_count_q;
	logic [SYMBITS_W-1:0] symbol_bits_q;

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	entry_t              mem_wdata, mem_rdata;
	res_t                res;
	logic                res_take;
	logic                out_valid_q;
	logic [SYMBOL_W-1:0] out_symbol_q;
	logic                out_status_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			symbol_bits_q <= SYMBOL_BITS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_ENTRY_COUNT: entry_count_q <= cfg.data[COUNT_W-1:0];
				REG_SYMBOL_BITS: symbol_bits_q <= cfg.data[SYMBITS_W-1:0];
				default: ;
			endcase
		end
	end

	pctd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pctd_scan #(
		.TABLE_DEPTH     (TABLE_DEPTH),
		.MAX_CODE_LEN    (MAX_CODE_LEN),
		.MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.entry_count (entry_count_q),
		.symbol_bits (symbol_bits_q),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.res         (res),
		.res_take    (res_take)
	);

	// The output register takes a new result when empty or being drained.
	assign res_take = res.valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_symbol_q <= res.symbol;
			out_status_q <= res.status;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.symbol = out_symbol_q;
	assign rsp.status = out_status_q;

	// No request may enter while a finished result is still held by the search unit.
	assert property (@(posedge clk) disable iff (!arst_n) res.valid |-> !req.ready)
		else $error("request port open while a result waits");

	// The table is never written and searched in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("table write during search");

	// An overflow result always carries a zero symbol.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_OVERFLOW)) |-> (rsp.symbol == '0))
		else $error("overflow result with nonzero symbol");

	// A result handed over is offered on the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) res_take |=> rsp.valid)
		else $error("result lost on its way to the output register");

endmodule

// ===== sim/tb_prefix_code_table_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_code_table_decoder
// Self-checking testbench for the prefix code table decoder.
// ----------------------------------------------------------------------------
// Loads codeword tables, streams code bits through the request channel and
// compares every decoded symbol or overflow result with a shadow copy of the
// table search. Sender and receiver stall at random, and entry_count and
// symbol_bits are swept through their extremes between phases.
// ----------------------------------------------------------------------------
module tb_prefix_code_table_decoder;
	import pctd_pkg::*;

	localparam int TABLE_SLOTS    = DEF_TABLE_DEPTH;
	localparam int CODE_LIMIT     = DEF_MAX_CODE_LEN;
	localparam int SYMBOL_LIMIT   = DEF_MAX_SYMBOL_BITS;
	localparam int STALL_MAX      = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = '1;

	// Phase settings; negative values select a random draw.
	localparam int PICK_ANY   = -1;
	localparam int PICK_SMALL = -2;
	localparam int PHASE_COUNT   [PHASES] = '{256, 'hFFFF, 0, 1, PICK_SMALL, PICK_ANY, 256};
	localparam int PHASE_SYMBITS [PHASES] = '{8, 'hFFFF, 0, 1, PICK_SMALL, PICK_ANY, 3};
	localparam int PHASE_ITEMS   [PHASES] = '{20, 15, 10, 10, 20, 25, 20};

	typedef struct packed {
		logic                op;
		logic                code_bit;
		logic [INDEX_W-1:0]  index;
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
		logic [SYMBOL_W-1:0] sym;
	} request_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                status;
	} decoded_t;

	logic clk;
	logic arst_n;

	pctd_req_if req ();
	pctd_rsp_if rsp ();
	pctd_cfg_if cfg ();

	prefix_code_table_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	entry_t               shadow_table [TABLE_SLOTS];
	logic [CODE_W-1:0]    shadow_code;
	int                   shadow_len;
	logic [COUNT_W-1:0]   shadow_count;
	logic [SYMBITS_W-1:0] shadow_symbits;
	decoded_t             expected_symbols [$];

	bit steady_flow;
	int errors;
	int n_requests;
	int n_bits;
	int n_symbols;
	int n_overflows;
	int n_cfg_writes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] low_bits(int n);
		return (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
	endfunction

	function automatic int search_span();
		return (shadow_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(shadow_count);
	endfunction

	// Appends one result to the tail of the expected list.
	function automatic void queue_result(decoded_t d);
		expected_symbols.insert(expected_symbols.size(), d);
	endfunction

	// Applies one accepted request to the shadow state and queues the result
	// that it must produce, if any.
	function automatic void decode_request(request_t r);
		int i;
		int width;
		bit hit;
		logic [SYMBOL_W-1:0] sym;
		decoded_t outcome;
		hit = 1'b0;
		sym = '0;
		if (r.op == OP_LOAD) begin
			shadow_table[r.index] = '{code: r.code, len: r.len, sym: r.sym};
			return;
		end
		if (shadow_len < CODE_LIMIT) begin
			shadow_code = {shadow_code[CODE_W-2:0], r.code_bit};
			shadow_len++;
		end
		for (i = 0; i < search_span() && !hit; i++) begin
			if (shadow_table[i].len != '0 && int'(shadow_table[i].len) == shadow_len &&
			    (32'(shadow_table[i].code) & low_bits(shadow_len)) == 32'(shadow_code)) begin
				hit = 1'b1;
				sym = shadow_table[i].sym;
			end
		end
		if (hit) begin
			width = (shadow_symbits > SYMBOL_LIMIT) ? SYMBOL_LIMIT : int'(shadow_symbits);
			outcome = '{symbol: SYMBOL_W'(32'(sym) & low_bits(width)), status: ST_SYMBOL};
			queue_result(outcome);
			shadow_code = '0;
			shadow_len = 0;
		end else if (shadow_len >= CODE_LIMIT) begin
			outcome = '{symbol: '0, status: ST_OVERFLOW};
			queue_result(outcome);
			shadow_code = '0;
			shadow_len = 0;
		end
	endfunction

	function automatic request_t make_bit(logic b);
		request_t r;
		r.op = OP_BIT;
		r.code_bit = b;
		r.index = INDEX_W'($urandom);
		r.code = CODE_W'($urandom);
		r.len = LEN_W'($urandom);
		r.sym = SYMBOL_W'($urandom);
		return r;
	endfunction

	function automatic request_t make_load(int idx, logic [CODE_W-1:0] code, int len,
		logic [SYMBOL_W-1:0] sym);
		request_t r;
		r.op = OP_LOAD;
		r.code_bit = 1'($urandom);
		r.index = INDEX_W'(idx);
		r.code = code;
		r.len = LEN_W'(len);
		r.sym = sym;
		return r;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		errors++;
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endtask

	// A request stays valid after acceptance until the next falling edge, where
	// it is either replaced, dropped for a gap, or dropped here.
	task automatic release_request();
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic send_request(request_t r);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.op <= r.op;
		req.code_bit <= r.code_bit;
		req.entry_index <= r.index;
		req.entry_code <= r.code;
		req.entry_code_len <= r.len;
		req.entry_symbol <= r.sym;
		do @(posedge clk); while (!(req.valid && req.ready));
		decode_request(r);
		n_requests++;
		if (r.op == OP_BIT)
			n_bits++;
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		if (index == REG_ENTRY_COUNT)
			shadow_count = data[COUNT_W-1:0];
		else if (index == REG_SYMBOL_BITS)
			shadow_symbits = data[SYMBITS_W-1:0];
		n_cfg_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		release_request();
		while (expected_symbols.size() != 0) @(posedge clk);
	endtask

	// A bit request that yields no result may still be walking the table, so
	// allow a full search before the block is treated as idle.
	task automatic wait_until_idle();
		wait_results_drained();
		repeat (search_span() + 16) @(posedge clk);
	endtask

	// Streams the codeword of a random searched slot, or a noise bit when no
	// usable slot turns up.
	task automatic send_codeword();
		int span;
		int tries;
		int b;
		bit found;
		entry_t e;
		span = search_span();
		found = 1'b0;
		e = '0;
		for (tries = 0; tries < 8 && !found && span > 0; tries++) begin
			e = shadow_table[$urandom_range(0, span - 1)];
			found = (e.len != '0 && e.len <= CODE_LIMIT);
		end
		if (found) begin
			for (b = int'(e.len) - 1; b >= 0; b--)
				send_request(make_bit(e.code[b]));
		end else begin
			send_request(make_bit(1'($urandom)));
		end
	endtask

	task automatic test_directed_cases();
		int i;
		logic [CODE_W-1:0] stream;
		// Upper code bits beyond the length are ignored: slot 0 decodes "1".
		send_request(make_load(0, 16'hFFFF, 1, 8'hFF));
		send_request(make_load(1, 16'h0001, 2, 8'h80));
		// Zero length and a length above the maximum can never match.
		send_request(make_load(2, 16'h0000, 0, 8'h11));
		send_request(make_load(3, 16'h0000, 31, 8'h22));
		send_request(make_load(4, 16'h0000, 16, 8'h5A));
		send_request(make_load(5, 16'h0003, 2, 8'h44));
		send_request(make_load(255, 16'hAAAA, 16, 8'h33));
		// With no entries searched, sixteen bits end in an overflow.
		stream = 16'hA5C3;
		for (i = CODE_W - 1; i >= 0; i--)
			send_request(make_bit(stream[i]));
		wait_until_idle();
		write_register(REG_ENTRY_COUNT, CFG_DATA_W'(6));
		write_register(REG_SYMBOL_BITS, CFG_DATA_W'(8));
		send_request(make_bit(1'b1));
		// A load in the middle of a codeword leaves the pending bits alone.
		send_request(make_bit(1'b0));
		send_request(make_load(5, 16'h0002, 2, 8'h9C));
		send_request(make_bit(1'b1));
	endtask

	// Fills every slot: a canonical prefix code from slot zero, then random
	// entries if the code space runs out first.
	task automatic test_table_load();
		int slot;
		int len;
		int step;
		bit full;
		logic [31:0] next_code;
		len = $urandom_range(2, 5);
		next_code = '0;
		slot = 0;
		full = 1'b0;
		while (slot < TABLE_SLOTS && !full) begin
			send_request(make_load(slot, CODE_W'(next_code) | CODE_W'($urandom() << len), len,
				SYMBOL_W'($urandom)));
			slot++;
			next_code++;
			if (next_code >= (32'd1 << len)) begin
				full = 1'b1;
			end else begin
				step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				if (len + step > CODE_LIMIT)
					step = CODE_LIMIT - len;
				next_code = next_code << step;
				len += step;
			end
		end
		for (; slot < TABLE_SLOTS; slot++)
			send_request(make_load(slot, CODE_W'($urandom), $urandom_range(0, 31),
				SYMBOL_W'($urandom)));
	endtask

	task automatic test_decode_phases();
		int p;
		int target;
		int pick;
		bit drained;
		logic [CFG_DATA_W-1:0] count_data;
		logic [CFG_DATA_W-1:0] symbits_data;
		for (p = 0; p < PHASES; p++) begin
			wait_until_idle();
			if (PHASE_COUNT[p] == PICK_ANY)
				count_data = CFG_DATA_W'($urandom);
			else if (PHASE_COUNT[p] == PICK_SMALL)
				count_data = CFG_DATA_W'($urandom_range(2, 40));
			else
				count_data = CFG_DATA_W'(PHASE_COUNT[p]);
			if (PHASE_SYMBITS[p] == PICK_ANY)
				symbits_data = CFG_DATA_W'($urandom);
			else if (PHASE_SYMBITS[p] == PICK_SMALL)
				symbits_data = CFG_DATA_W'($urandom_range(1, SYMBOL_LIMIT));
			else
				symbits_data = CFG_DATA_W'(PHASE_SYMBITS[p]);
			write_register(REG_ENTRY_COUNT, count_data);
			write_register(REG_SYMBOL_BITS, symbits_data);
			// Writes to unused indexes must leave both registers untouched.
			write_register((p % 2 == 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
			steady_flow = (p == 4);
			target = n_requests + PHASE_ITEMS[p];
			drained = 1'b0;
			while (n_requests < target) begin
				if (p == 5 && !drained && n_requests >= target - PHASE_ITEMS[p] / 2) begin
					wait_results_drained();
					drained = 1'b1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_codeword();
				else if (pick < 9)
					send_request(make_bit(1'($urandom)));
				else
					send_request(make_load($urandom_range(0, TABLE_SLOTS - 1),
						CODE_W'($urandom), $urandom_range(0, 31), SYMBOL_W'($urandom)));
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin : result_check
		decoded_t want;
		int stall;
		rsp.ready = 1'b0;
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
			if (expected_symbols.size() == 0) begin
				report_mismatch("unrequested result, symbol", 0, int'(rsp.symbol));
			end else begin
				want = expected_symbols.pop_front();
				if (rsp.symbol !== want.symbol)
					report_mismatch("symbol", int'(want.symbol), int'(rsp.symbol));
				if (rsp.status !== want.status)
					report_mismatch("status", int'(want.status), int'(rsp.status));
				if (want.status == ST_OVERFLOW)
					n_overflows++;
				else
					n_symbols++;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_LOAD;
		req.code_bit = 1'b0;
		req.entry_index = '0;
		req.entry_code = '0;
		req.entry_code_len = '0;
		req.entry_symbol = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_ENTRY_COUNT;
		cfg.data = '0;
		foreach (shadow_table[i])
			shadow_table[i] = '0;
		shadow_code = '0;
		shadow_len = 0;
		shadow_count = '0;
		shadow_symbits = SYMBOL_BITS_RESET;
		steady_flow = 1'b0;
		errors = 0;
		n_requests = 0;
		n_bits = 0;
		n_symbols = 0;
		n_overflows = 0;
		n_cfg_writes = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_table_load();
		test_decode_phases();
		wait_until_idle();

		$display("covered %0d requests (%0d code bits); %0d symbols and %0d overflows checked",
			n_requests, n_bits, n_symbols, n_overflows);
		$display("%0d register writes, entry counts from 0 past the table depth, widths 0 to 15",
			n_cfg_writes);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
